// ===== src/wcce_pkg.sv =====
// Shared types and constants for the wire-chamber cluster expander.
// Used by wcce_ctrl, wcce_datapath and the top level; depends on nothing.
`default_nettype none

package wcce_pkg;

    localparam int CODE_W   = 11;
    localparam int SIZE_W   = 8;
    localparam int CFG_W    = 5;
    localparam int WIRE_W   = 12;
    localparam int HITS_W   = 14;
    localparam int CLUS_W   = 7;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;

    // Result kinds.
    localparam logic [KIND_W-1:0] KIND_WIRE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POS  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SUM  = 2'd2;

    // Event status codes.
    localparam logic [STATUS_W-1:0] EVT_NONE     = 2'd0;
    localparam logic [STATUS_W-1:0] EVT_SINGLE   = 2'd1;
    localparam logic [STATUS_W-1:0] EVT_MULTIPLE = 2'd2;

    // Input command codes.
    localparam logic CMD_CLUSTER = 1'b0;
    localparam logic CMD_END     = 1'b1;

    localparam logic [HITS_W-1:0] HITS_MAX       = 14'h3FFF;
    localparam logic [CFG_W-1:0]  CFG_SIZE_RESET = 5'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic emit_wire;
        logic emit_pos;
        logic emit_sum;
    } wcce_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic end_item;
        logic drop;
        logic no_wires;
        logic last_wire;
        logic slot_free;
    } wcce_status_t;

endpackage

`default_nettype wire

// ===== src/wcce_datapath.sv =====
// Datapath of the cluster expander: item registers, wire counter, event totals
// and the output register.  Depends on wcce_pkg.
`default_nettype none

module wcce_datapath #(
    parameter int MAX_CLUSTERS = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire wcce_pkg::wcce_cmd_t             cmd_in,
    output wcce_pkg::wcce_status_t               status,
    input  wire logic                            cfg_we,
    input  wire logic [wcce_pkg::CFG_W-1:0]      cfg_data,
    input  wire logic                            item_cmd,
    input  wire logic [wcce_pkg::CODE_W-1:0]     item_code,
    input  wire logic [wcce_pkg::SIZE_W-1:0]     item_size,
    input  wire logic                            out_stall,
    output logic                                 out_valid,
    output logic [wcce_pkg::KIND_W-1:0]          kind,
    output logic signed [wcce_pkg::WIRE_W-1:0]   wire_number,
    output logic [wcce_pkg::CODE_W-1:0]          position_half,
    output logic                                 parity_error,
    output logic [wcce_pkg::HITS_W-1:0]          hit_count,
    output logic [wcce_pkg::CLUS_W-1:0]          cluster_count,
    output logic [wcce_pkg::STATUS_W-1:0]        event_status,
    output logic                                 overflow,
    output logic                                 last
);

    localparam logic [wcce_pkg::CLUS_W-1:0] MaxClus = wcce_pkg::CLUS_W'(MAX_CLUSTERS);

    logic [wcce_pkg::CFG_W-1:0]         max_size_reg;
    logic [wcce_pkg::CODE_W-1:0]        code_reg;
    logic                               perr_reg;
    logic [wcce_pkg::SIZE_W-1:0]        hit_add_reg;
    logic [wcce_pkg::CFG_W-1:0]         rem_reg;
    logic signed [wcce_pkg::WIRE_W-1:0] wire_cur_reg;
    logic [wcce_pkg::HITS_W-1:0]        hits_reg;
    logic [wcce_pkg::CLUS_W-1:0]        clus_reg;
    logic                               limit_reg;
    logic                               out_valid_reg;

    logic                               in_perr;
    logic [wcce_pkg::CFG_W-1:0]         clamped;
    logic [wcce_pkg::CFG_W-1:0]         n_wires;
    logic [wcce_pkg::WIRE_W:0]          diff;
    logic [wcce_pkg::HITS_W:0]          hits_sum;
    logic [wcce_pkg::CLUS_W-1:0]        clus_inc;
    logic [wcce_pkg::STATUS_W-1:0]      evt_code;
    logic                               emit_any;

    // An odd sum of code and size is consistent, so parity error is an even sum.
    assign in_perr = ~(item_code[0] ^ item_size[0]);
    assign clamped = (item_size > {3'b000, max_size_reg}) ? max_size_reg
                                                          : item_size[wcce_pkg::CFG_W-1:0];
    assign n_wires = in_perr ? '0 : clamped;
    // Floor halving of code minus clamped size: arithmetic shift of a 13-bit difference.
    assign diff    = {2'b00, item_code} - {8'h00, clamped};

    assign hits_sum = {1'b0, hits_reg} + {7'h00, hit_add_reg};
    assign clus_inc = clus_reg + 7'd1;
    assign emit_any = cmd_in.emit_wire | cmd_in.emit_pos | cmd_in.emit_sum;

    always_comb
    begin
        if (clus_reg == '0)
            evt_code = wcce_pkg::EVT_NONE;
        else if (clus_reg == 7'd1)
            evt_code = wcce_pkg::EVT_SINGLE;
        else
            evt_code = wcce_pkg::EVT_MULTIPLE;
    end

    assign status.end_item  = (item_cmd == wcce_pkg::CMD_END);
    assign status.drop      = limit_reg | (clus_reg >= MaxClus);
    assign status.no_wires  = (n_wires == '0);
    assign status.last_wire = (rem_reg == 5'd1);
    assign status.slot_free = ~out_valid_reg | ~out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_size_reg <= wcce_pkg::CFG_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            max_size_reg <= cfg_data;
        end
    end

    // Item registers and wire counter.
    always_ff @(posedge clk)
    begin
        if (cmd_in.load)
        begin
            code_reg     <= item_code;
            perr_reg     <= in_perr;
            hit_add_reg  <= in_perr ? item_size : {3'b000, clamped};
            rem_reg      <= n_wires;
            wire_cur_reg <= diff[wcce_pkg::WIRE_W:1];
        end
        else if (cmd_in.emit_wire)
        begin
            rem_reg      <= rem_reg - 5'd1;
            wire_cur_reg <= wire_cur_reg + 12'sd1;
        end
    end

    // Event totals.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg  <= '0;
            clus_reg  <= '0;
            limit_reg <= 1'b0;
        end
        else if (cmd_in.emit_sum)
        begin
            hits_reg  <= '0;
            clus_reg  <= '0;
            limit_reg <= 1'b0;
        end
        else if (cmd_in.emit_pos)
        begin
            hits_reg  <= hits_sum[wcce_pkg::HITS_W] ? wcce_pkg::HITS_MAX
                                                    : hits_sum[wcce_pkg::HITS_W-1:0];
            clus_reg  <= clus_inc;
            if (clus_inc >= MaxClus)
                limit_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_any)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    // Output register; fields that do not belong to the kind are zero.
    always_ff @(posedge clk)
    begin
        if (emit_any)
        begin
            wire_number   <= '0;
            position_half <= '0;
            parity_error  <= 1'b0;
            hit_count     <= '0;
            cluster_count <= '0;
            event_status  <= wcce_pkg::EVT_NONE;
            overflow      <= 1'b0;
            last          <= 1'b1;
            if (cmd_in.emit_wire)
            begin
                kind        <= wcce_pkg::KIND_WIRE;
                wire_number <= wire_cur_reg;
                last        <= 1'b0;
            end
            else if (cmd_in.emit_pos)
            begin
                kind          <= wcce_pkg::KIND_POS;
                position_half <= code_reg;
                parity_error  <= perr_reg;
            end
            else
            begin
                kind          <= wcce_pkg::KIND_SUM;
                hit_count     <= hits_reg;
                cluster_count <= clus_reg;
                event_status  <= evt_code;
                overflow      <= limit_reg;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ===== src/wcce_ctrl.sv =====
// Controller state machine of the cluster expander: sequences one input item
// into its results.  Depends on wcce_pkg.
`default_nettype none

module wcce_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire wcce_pkg::wcce_status_t status,
    output wcce_pkg::wcce_cmd_t         cmd_out
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WIRE = 2'd1;
    localparam logic [1:0] ST_POS  = 2'd2;
    localparam logic [1:0] ST_SUM  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next        = state_reg;
        cmd_out.load      = 1'b0;
        cmd_out.emit_wire = 1'b0;
        cmd_out.emit_pos  = 1'b0;
        cmd_out.emit_sum  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_out.load = 1'b1;
                    if (status.end_item)
                        state_next = ST_SUM;
                    else if (status.drop)
                        state_next = ST_IDLE;
                    else if (status.no_wires)
                        state_next = ST_POS;
                    else
                        state_next = ST_WIRE;
                end
            end
            ST_WIRE:
            begin
                if (status.slot_free)
                begin
                    cmd_out.emit_wire = 1'b1;
                    if (status.last_wire)
                        state_next = ST_POS;
                end
            end
            ST_POS:
            begin
                if (status.slot_free)
                begin
                    cmd_out.emit_pos = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_SUM:
            begin
                if (status.slot_free)
                begin
                    cmd_out.emit_sum = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // At most one result is produced per cycle.
    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd_out.emit_wire, cmd_out.emit_pos, cmd_out.emit_sum}))
        else $error("more than one result produced in a cycle");

    // A result is only produced when the output register can take it.
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_out.emit_wire || cmd_out.emit_pos || cmd_out.emit_sum) |-> status.slot_free)
        else $error("result produced into an occupied output register");

    // An end-of-event item leads to the summary state.
    a_end_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_out.load && status.end_item) |=> (state_reg == ST_SUM))
        else $error("end of event did not reach the summary state");

    // The final wire of a cluster is followed by its position.
    a_wire_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_out.emit_wire && status.last_wire) |=> (state_reg == ST_POS))
        else $error("position did not follow the final wire");

endmodule

`default_nettype wire

// ===== src/wire_chamber_cluster_expander.sv =====
// Top level of the wire-chamber cluster expander: controller plus datapath.
// Depends on wcce_pkg, wcce_ctrl and wcce_datapath.
//
//   Channel   Handshake              Payload
//   -------   --------------------   -------------------------------------------
//   input     in_valid / in_stall    cmd, wire_code, cluster_size
//   output    out_valid / out_stall  kind, wire_number, position_half,
//                                    parity_error, hit_count, cluster_count,
//                                    event_status, overflow, last
//   config    cfg_valid / cfg_ready  cfg_data (max_cluster_size)
//
// A cluster word is first captured, then one result per cycle is produced for each wire
// expanded and for the position while the output is not stalled.  An end of event is
// captured and then gives its summary; a dropped cluster word is only captured.
// The controller handles one item at a time.  Reset clears the controller, the event
// totals and the output valid flag, and sets max_cluster_size to 16.  A stall on the
// output holds the current result in the output register and pauses the wire sequence.
`default_nettype none

module wire_chamber_cluster_expander #(
    parameter int MAX_CLUSTERS = 64
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Input channel.
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire logic                               cmd,
    input  wire logic [wcce_pkg::CODE_W-1:0]        wire_code,
    input  wire logic [wcce_pkg::SIZE_W-1:0]        cluster_size,
    // Output channel.
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output logic [wcce_pkg::KIND_W-1:0]             kind,
    output logic signed [wcce_pkg::WIRE_W-1:0]      wire_number,
    output logic [wcce_pkg::CODE_W-1:0]             position_half,
    output logic                                    parity_error,
    output logic [wcce_pkg::HITS_W-1:0]             hit_count,
    output logic [wcce_pkg::CLUS_W-1:0]             cluster_count,
    output logic [wcce_pkg::STATUS_W-1:0]           event_status,
    output logic                                    overflow,
    output logic                                    last,
    // Configuration channel.
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [wcce_pkg::CFG_W-1:0]         cfg_data
);

    wcce_pkg::wcce_cmd_t    ctrl_cmd;
    wcce_pkg::wcce_status_t dp_status;

    // Always ready; the user must issue writes only when idle, as nothing enforces it.
    assign cfg_ready = 1'b1;

    wcce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (dp_status),
        .cmd_out  (ctrl_cmd)
    );

    wcce_datapath #(
        .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd_in        (ctrl_cmd),
        .status        (dp_status),
        .cfg_we        (cfg_valid & cfg_ready),
        .cfg_data      (cfg_data),
        .item_cmd      (cmd),
        .item_code     (wire_code),
        .item_size     (cluster_size),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .kind          (kind),
        .wire_number   (wire_number),
        .position_half (position_half),
        .parity_error  (parity_error),
        .hit_count     (hit_count),
        .cluster_count (cluster_count),
        .event_status  (event_status),
        .overflow      (overflow),
        .last          (last)
    );

endmodule

`default_nettype wire

// ===== bench/wire_chamber_cluster_expander_tb.sv =====
// Self-checking testbench for the wire-chamber cluster expander; needs wcce_pkg and the RTL.
// It predicts every result itself and runs the reset settings, directed field and register
// extremes, the cluster limit, random events and a final stretch at full rate.

module wire_chamber_cluster_expander_tb;

    import wcce_pkg::*;

    localparam int CLUSTER_LIMIT  = 64;
    // Cycles allowed after the last expected result so that a dropped word or a stray
    // result can still show itself.
    localparam int QUIET_CYCLES   = 40;
    // Cycles without any transfer before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 1000;

    // One result as the block should present it. Fields that do not belong to the
    // kind are zero.
    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic signed [WIRE_W-1:0]   wire_number;
        logic [CODE_W-1:0]          position_half;
        logic                       parity_error;
        logic [HITS_W-1:0]          hit_count;
        logic [CLUS_W-1:0]          cluster_count;
        logic [STATUS_W-1:0]        event_status;
        logic                       overflow;
        logic                       last;
    } chamber_result_t;

    logic                       clk;
    logic                       rst_n;
    logic                       in_valid;
    logic                       in_stall;
    logic                       cmd;
    logic [CODE_W-1:0]          wire_code;
    logic [SIZE_W-1:0]          cluster_size;
    logic                       out_valid;
    logic                       out_stall;
    logic [KIND_W-1:0]          kind;
    logic signed [WIRE_W-1:0]   wire_number;
    logic [CODE_W-1:0]          position_half;
    logic                       parity_error;
    logic [HITS_W-1:0]          hit_count;
    logic [CLUS_W-1:0]          cluster_count;
    logic [STATUS_W-1:0]        event_status;
    logic                       overflow;
    logic                       last;
    logic                       cfg_valid;
    logic                       cfg_ready;
    logic [CFG_W-1:0]           cfg_data;

    // The bench's own copy of the register and of the per-event totals.
    logic [CFG_W-1:0]           max_size_shadow;
    int                         event_hit_total;
    int                         event_cluster_total;
    logic                       event_limit_hit;

    // Results still owed by the block, oldest first.
    chamber_result_t            awaited_results[$];
    chamber_result_t            head_result;

    int                         failures;
    int                         items_sent;
    int                         results_checked;
    int                         summaries_predicted;
    int                         limit_events;
    int                         cfg_writes;
    int                         quiet_cycles;
    int                         stall_pick;

    // When calm is set neither side idles; sender_gappy switches the sender's gaps on
    // and off per phase so that some stretches run without them.
    logic                       calm;
    logic                       sender_gappy;

    wire_chamber_cluster_expander #(
        .MAX_CLUSTERS   (CLUSTER_LIMIT)
    ) i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .wire_code      (wire_code),
        .cluster_size   (cluster_size),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .kind           (kind),
        .wire_number    (wire_number),
        .position_half  (position_half),
        .parity_error   (parity_error),
        .hit_count      (hit_count),
        .cluster_count  (cluster_count),
        .event_status   (event_status),
        .overflow       (overflow),
        .last           (last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Works out the results that one accepted input item causes and queues them. The
    // event totals are updated exactly as the block should update its own.
    task automatic predict_cluster_output(input logic c, input logic [CODE_W-1:0] code,
                                          input logic [SIZE_W-1:0] size);
        chamber_result_t res;
        int span;
        int first_wire;
        logic flawed;
        if (c == CMD_END)
        begin
            res = '0;
            res.kind = KIND_SUM;
            res.hit_count = HITS_W'(event_hit_total);
            res.cluster_count = CLUS_W'(event_cluster_total);
            if (event_cluster_total == 0)
                res.event_status = EVT_NONE;
            else if (event_cluster_total == 1)
                res.event_status = EVT_SINGLE;
            else
                res.event_status = EVT_MULTIPLE;
            res.overflow = event_limit_hit;
            res.last = 1'b1;
            awaited_results.push_back(res);
            summaries_predicted++;
            if (event_limit_hit)
                limit_events++;
            event_hit_total = 0;
            event_cluster_total = 0;
            event_limit_hit = 1'b0;
        end
        else if (!event_limit_hit && event_cluster_total < CLUSTER_LIMIT)
        begin
            // Code plus size is even exactly when the two low bits agree.
            flawed = (code[0] == size[0]);
            span = size;
            if (!flawed)
            begin
                if (span > max_size_shadow)
                    span = max_size_shadow;
                // An arithmetic shift of a signed int rounds towards minus infinity.
                first_wire = (int'(code) - span) >>> 1;
                for (int j = 0; j < span; j++)
                begin
                    res = '0;
                    res.kind = KIND_WIRE;
                    res.wire_number = WIRE_W'(first_wire + j);
                    awaited_results.push_back(res);
                end
            end
            // A flawed word still adds its full, unclamped size.
            event_hit_total = event_hit_total + span;
            if (event_hit_total > HITS_MAX)
                event_hit_total = HITS_MAX;
            res = '0;
            res.kind = KIND_POS;
            res.position_half = code;
            res.parity_error = flawed;
            res.last = 1'b1;
            awaited_results.push_back(res);
            event_cluster_total++;
            if (event_cluster_total >= CLUSTER_LIMIT)
                event_limit_hit = 1'b1;
        end
    endtask

    // Forces the low bit of a random code so that code plus size has the parity wanted.
    function automatic logic [CODE_W-1:0] code_for(input logic [CODE_W-1:0] raw,
                                                   input logic [SIZE_W-1:0] size,
                                                   input logic flawed);
        return {raw[CODE_W-1:1], size[0] ^ ~flawed};
    endfunction

    // Presents one item and waits for its transfer. Valid is left high on return, so
    // the caller either sends the next item at once or lowers it before waiting.
    task automatic send_item(input logic c, input logic [CODE_W-1:0] code,
                             input logic [SIZE_W-1:0] size);
        if (!calm && sender_gappy && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        wire_code <= code;
        cluster_size <= size;
        do
            @(posedge clk);
        while (in_stall);
        predict_cluster_output(c, code, size);
        items_sent++;
    endtask

    // Holds the sender back until every awaited result has been checked, then lets
    // the block finish any dropped word.
    task automatic settle_block();
        in_valid <= 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    // Writes max_cluster_size once the block is idle.
    task automatic write_max_size(input logic [CFG_W-1:0] value);
        settle_block();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        max_size_shadow = value;
        cfg_writes++;
    endtask

    task automatic compare_field(input string name, input logic signed [31:0] expected,
                                 input logic signed [31:0] actual);
        if (actual !== expected)
        begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            failures++;
        end
    endtask

    // An empty event, then a large cluster that the reset value of the register must
    // clamp to sixteen wires.
    task automatic test_reset_settings();
        send_item(CMD_END, CODE_W'($urandom), SIZE_W'($urandom));
        send_item(CMD_CLUSTER, 11'd100, 8'd21);
        send_item(CMD_END, CODE_W'($urandom), SIZE_W'($urandom));
    endtask

    // Field extremes: negative wire numbers, the top code, zero size and parity errors.
    task automatic test_field_extremes();
        send_item(CMD_CLUSTER, 11'd0, 8'd1);
        send_item(CMD_CLUSTER, 11'd0, 8'd255);
        send_item(CMD_CLUSTER, 11'd2047, 8'd0);
        send_item(CMD_CLUSTER, 11'd2047, 8'd255);
        send_item(CMD_CLUSTER, 11'd0, 8'd0);
        send_item(CMD_CLUSTER, 11'd1, 8'd16);
        send_item(CMD_CLUSTER, 11'd1366, 8'd170);
        send_item(CMD_END, 11'd2047, 8'd255);
    endtask

    // Register extremes: a clamp to nothing, the widest clusters at both ends of the
    // chamber, a single wire, and finally the reset value again.
    task automatic test_size_limits();
        write_max_size(5'd0);
        send_item(CMD_CLUSTER, 11'd10, 8'd5);
        send_item(CMD_CLUSTER, 11'd10, 8'd4);
        send_item(CMD_END, 11'd0, 8'd0);
        write_max_size(5'd31);
        send_item(CMD_CLUSTER, 11'd0, 8'd31);
        send_item(CMD_CLUSTER, 11'd2046, 8'd255);
        send_item(CMD_CLUSTER, 11'd2047, 8'd30);
        send_item(CMD_END, 11'd0, 8'd0);
        write_max_size(5'd1);
        send_item(CMD_CLUSTER, 11'd5, 8'd2);
        send_item(CMD_END, 11'd0, 8'd0);
        write_max_size(CFG_SIZE_RESET);
    endtask

    // Runs one event past the cluster limit, mostly with flawed full-size words so the
    // hit total climbs high, then checks that the next event starts clean.
    task automatic test_cluster_limit();
        int n;
        logic flawed;
        logic [SIZE_W-1:0] size;
        for (n = 0; n < CLUSTER_LIMIT + 4; n++)
        begin
            flawed = (n % 4 != 0);
            size = flawed ? 8'd255 : SIZE_W'($urandom_range(0, 6));
            send_item(CMD_CLUSTER, code_for(CODE_W'($urandom), size, flawed), size);
        end
        send_item(CMD_END, CODE_W'($urandom), SIZE_W'($urandom));
        send_item(CMD_CLUSTER, code_for(CODE_W'($urandom), 8'd3, 1'b0), 8'd3);
        send_item(CMD_END, CODE_W'($urandom), SIZE_W'($urandom));
    endtask

    // Random events of mostly consistent words with random content, a few long events
    // and stray ends as noise. Phases alternate between a register write and a plain
    // pause until every result is in.
    task automatic test_random_events();
        int phase;
        int n;
        int event_left;
        logic [SIZE_W-1:0] size;
        for (phase = 0; phase < 5; phase++)
        begin
            if (phase % 2 == 0)
                write_max_size(CFG_W'($urandom_range(0, 31)));
            else
                settle_block();
            sender_gappy = ($urandom_range(0, 3) != 0);
            event_left = $urandom_range(0, 6);
            for (n = 0; n < 32; n++)
            begin
                if (event_left == 0 || $urandom_range(0, 11) == 0)
                begin
                    send_item(CMD_END, CODE_W'($urandom), SIZE_W'($urandom));
                    if ($urandom_range(0, 7) == 0)
                        event_left = $urandom_range(10, 30);
                    else
                        event_left = $urandom_range(0, 6);
                end
                else
                begin
                    if ($urandom_range(0, 3) != 0)
                        size = SIZE_W'($urandom_range(0, 40));
                    else
                        size = SIZE_W'($urandom);
                    send_item(CMD_CLUSTER,
                              code_for(CODE_W'($urandom), size, $urandom_range(0, 3) == 0),
                              size);
                    event_left--;
                end
            end
        end
        sender_gappy = 1'b1;
    endtask

    // Short events sent back to back with the receiver never stalling, so that the
    // block runs at its full rate.
    task automatic test_back_to_back();
        int n;
        logic [SIZE_W-1:0] size;
        calm = 1'b1;
        // The write settles the block first, which also outlasts any stall burst.
        write_max_size(CFG_W'($urandom_range(4, 31)));
        for (n = 0; n < 30; n++)
        begin
            if (n % 5 == 4)
                send_item(CMD_END, CODE_W'($urandom), SIZE_W'($urandom));
            else
            begin
                size = SIZE_W'($urandom_range(0, 6));
                send_item(CMD_CLUSTER, code_for(CODE_W'($urandom), size, n % 7 == 3), size);
            end
        end
    endtask

    // Receiver stalls: short random bursts, long clear stretches now and then, and none
    // at all once the final part of the run has begun.
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (calm)
                out_stall <= 1'b0;
            else
            begin
                stall_pick = $urandom_range(0, 15);
                if (stall_pick == 0)
                begin
                    out_stall <= 1'b0;
                    repeat ($urandom_range(30, 60)) @(posedge clk);
                end
                else if (stall_pick <= 2)
                begin
                    out_stall <= 1'b1;
                    repeat ($urandom_range(1, 17)) @(posedge clk);
                    out_stall <= 1'b0;
                end
                else
                    out_stall <= 1'b0;
            end
        end
    end

    // Every result transfer is matched against the oldest awaited result. Outputs are
    // sampled at the clock edge, before the block's own updates for that edge land.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_results.size() == 0)
            begin
                $error("result of kind %0d arrived with nothing awaited", kind);
                failures++;
            end
            else
            begin
                head_result = awaited_results.pop_front();
                compare_field("kind", head_result.kind, kind);
                compare_field("wire_number", head_result.wire_number, wire_number);
                compare_field("position_half", head_result.position_half, position_half);
                compare_field("parity_error", head_result.parity_error, parity_error);
                compare_field("hit_count", head_result.hit_count, hit_count);
                compare_field("cluster_count", head_result.cluster_count, cluster_count);
                compare_field("event_status", head_result.event_status, event_status);
                compare_field("overflow", head_result.overflow, overflow);
                compare_field("last", head_result.last, last);
                results_checked++;
            end
        end
    end

    // Ends the run if no transfer of any kind happens for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: %0d cycles without a transfer, %0d results outstanding.",
                     quiet_cycles, awaited_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        cmd <= CMD_CLUSTER;
        wire_code <= '0;
        cluster_size <= '0;
        cfg_valid <= 1'b0;
        cfg_data <= '0;
        calm = 1'b0;
        sender_gappy = 1'b1;
        failures = 0;
        items_sent = 0;
        results_checked = 0;
        summaries_predicted = 0;
        limit_events = 0;
        cfg_writes = 0;
        max_size_shadow = CFG_SIZE_RESET;
        event_hit_total = 0;
        event_cluster_total = 0;
        event_limit_hit = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        test_reset_settings();
        test_field_extremes();
        test_size_limits();
        test_cluster_limit();
        test_random_events();
        test_back_to_back();
        settle_block();

        $display("Sent %0d items and checked %0d results, %0d of them event summaries.",
                 items_sent, results_checked, summaries_predicted);
        $display("The register was written %0d times; %0d events reached the cluster limit.",
                 cfg_writes, limit_events);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
